>>> design/arp_rc_pkg.sv
// Package for the ARP receive cache: request and result structs, cache entry
// layout, outcome and register codes, and the sequencer state type.
// No dependencies; every other design file but arp_rc_ram imports it.
`timescale 1ns / 1ps
`default_nettype none

package arp_rc_pkg;

  // Message checks
  localparam logic [15:0] ARP_MIN_LEN   = 16'd28;
  localparam logic [15:0] HTYPE_ETH     = 16'h0001;
  localparam logic [15:0] PTYPE_IPV4    = 16'h0800;
  localparam logic [15:0] OP_REQUEST    = 16'h0001;

  // Outcome codes
  localparam logic [2:0] OUT_SHORT     = 3'd0;
  localparam logic [2:0] OUT_BAD_HW    = 3'd1;
  localparam logic [2:0] OUT_BAD_PROTO = 3'd2;
  localparam logic [2:0] OUT_UPDATED   = 3'd3;
  localparam logic [2:0] OUT_INSERTED  = 3'd4;
  localparam logic [2:0] OUT_IGNORED   = 3'd5;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IFACE_EN = 2'd2;

  localparam logic [31:0] STAMP_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [15:0] msg_len;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [15:0] opcode;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [31:0] target_ip;
  } arp_in_t;

  typedef struct packed {
    logic [2:0]  outcome;
    logic [4:0]  entry_slot;
    logic        send_reply;
    logic [47:0] reply_sender_mac;
    logic [31:0] reply_sender_ip;
    logic [47:0] reply_target_mac;
    logic [31:0] reply_target_ip;
  } arp_out_t;

  typedef struct packed {
    logic [31:0] own_ip;
    logic [47:0] own_mac;
    logic        iface_enabled;
  } arp_cfg_t;

  // One cache slot as held in the entry RAM.
  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [31:0] stamp;
  } arp_entry_t;

  localparam int unsigned ENTRY_W = $bits(arp_entry_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } arp_state_t;

endpackage

`default_nettype wire

>>> design/arp_receive_cache_core.sv
// ARP receive cache, top level: result register, configuration registers,
// sequencer and entry RAM. Depends on arp_rc_pkg, arp_rc_ram, arp_rc_cfg and
// arp_rc_ctrl.
//
// Usage:
//   in_*  : one parsed ARP message per request (valid/ready).
//   out_* : one result per message (valid/ready), held in an output register
//           so the next message can be taken while a result waits.
//   cfg_* : register writes, own IP (0), own MAC (1), interface enable (2);
//           always ready, to be written only while the block is idle.
// Timing: a dropped message (short, wrong hardware or protocol type) goes
// straight from the idle state to the finishing state, and its result then
// passes through the output register to out_*. Any other message first scans
// every slot of the entry RAM, one read a cycle, before its result is
// finished; one message is handled at a time. The single RAM read port sets
// this.
// Reset clears the configuration, the slot valid flags and the write counter;
// the RAM needs no clearing pass. If the receiver stalls, a second finished
// result waits in the sequencer, which then takes no new message and makes no
// cache write until the output register can take that result.
`timescale 1ns / 1ps
`default_nettype none

module arp_receive_cache_core
  import arp_rc_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire arp_in_t              in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output arp_out_t                  out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [47:0]          cfg_data
);

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);

  arp_cfg_t         cfg;
  logic             res_valid;
  logic             res_ready;
  arp_out_t         res_data;
  logic             ram_rd_en;
  logic [AW-1:0]    ram_rd_addr;
  logic [ENTRY_W-1:0] ram_rd_data;
  logic             ram_wr_en;
  logic [AW-1:0]    ram_wr_addr;
  logic [ENTRY_W-1:0] ram_wr_data;
  logic             out_valid_r;
  arp_out_t         out_data_r;

  arp_rc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  arp_rc_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .cfg         (cfg),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_data    (res_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data)
  );

  arp_rc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // The output register takes a new result when empty or being emptied.
  assign res_ready = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

endmodule

`default_nettype wire

>>> design/arp_rc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module arp_rc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> design/arp_rc_cfg.sv
// Configuration registers of the ARP receive cache: own IP, own MAC and the
// interface enable. Depends on arp_rc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module arp_rc_cfg
  import arp_rc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [47:0]          cfg_data,
  output arp_cfg_t                  cfg
);

  arp_cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_OWN_IP:   cfg_r.own_ip        <= cfg_data[31:0];
        CFG_OWN_MAC:  cfg_r.own_mac       <= cfg_data;
        CFG_IFACE_EN: cfg_r.iface_enabled <= cfg_data[0];
        default:      ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/arp_rc_ctrl.sv
// Sequencer of the ARP receive cache: checks the message, scans the entry RAM
// for a sender match, a free slot and the oldest stamp, writes back on a hit
// or insert. Depends on arp_rc_pkg; drives an arp_rc_ram in the top level.
`timescale 1ns / 1ps
`default_nettype none

module arp_rc_ctrl
  import arp_rc_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire arp_in_t                          in_data,
  input  wire arp_cfg_t                         cfg,
  output logic                                  res_valid,
  input  wire logic                             res_ready,
  output arp_out_t                              res_data,
  output logic                                  ram_rd_en,
  output logic [$clog2(TABLE_ENTRIES)-1:0]      ram_rd_addr,
  input  wire logic [ENTRY_W-1:0]               ram_rd_data,
  output logic                                  ram_wr_en,
  output logic [$clog2(TABLE_ENTRIES)-1:0]      ram_wr_addr,
  output logic [ENTRY_W-1:0]                    ram_wr_data
);

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);

  arp_state_t           state_r, state_nxt;
  arp_in_t              req_r, req_nxt;
  logic                 drop_r, drop_nxt;
  logic [2:0]           drop_code_r, drop_code_nxt;
  logic [AW-1:0]        ptr_r, ptr_nxt;
  logic                 issue_on_r, issue_on_nxt;
  logic                 rd_vld_r, rd_vld_nxt;
  logic [AW-1:0]        rd_idx_r, rd_idx_nxt;
  logic                 found_r, found_nxt;
  logic [AW-1:0]        hit_slot_r, hit_slot_nxt;
  logic                 free_found_r, free_found_nxt;
  logic [AW-1:0]        free_slot_r, free_slot_nxt;
  logic [31:0]          min_stamp_r, min_stamp_nxt;
  logic [AW-1:0]        min_slot_r, min_slot_nxt;
  logic [31:0]          wcnt_r, wcnt_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r;

  arp_entry_t           rd_entry;
  arp_entry_t           wr_entry;
  logic                 rd_slot_valid;
  logic [31:0]          rd_stamp;
  logic                 for_us;
  logic [AW-1:0]        fin_slot;
  logic [AW+4:0]        fin_slot_ext;
  logic                 set_valid;
  logic [31:0]          stamp_new;

  assign rd_entry      = arp_entry_t'(ram_rd_data);
  assign rd_slot_valid = valid_r[rd_idx_r];
  // Free slots have not been written since reset, so treat their stamps as zero.
  assign rd_stamp      = rd_slot_valid ? rd_entry.stamp : 32'd0;
  assign for_us        = cfg.iface_enabled && (req_r.target_ip == cfg.own_ip);
  assign stamp_new     = (wcnt_r == STAMP_MAX) ? STAMP_MAX : wcnt_r + 32'd1;
  assign fin_slot_ext  = {5'd0, fin_slot};
  assign ram_wr_addr   = fin_slot;
  assign ram_wr_data   = ENTRY_W'(wr_entry);
  assign ram_rd_addr   = ptr_r;

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    drop_nxt       = drop_r;
    drop_code_nxt  = drop_code_r;
    ptr_nxt        = ptr_r;
    issue_on_nxt   = issue_on_r;
    rd_vld_nxt     = 1'b0;
    rd_idx_nxt     = rd_idx_r;
    found_nxt      = found_r;
    hit_slot_nxt   = hit_slot_r;
    free_found_nxt = free_found_r;
    free_slot_nxt  = free_slot_r;
    min_stamp_nxt  = min_stamp_r;
    min_slot_nxt   = min_slot_r;
    wcnt_nxt       = wcnt_r;
    in_ready       = 1'b0;
    res_valid      = 1'b0;
    res_data       = '0;
    ram_rd_en      = 1'b0;
    ram_wr_en      = 1'b0;
    set_valid      = 1'b0;
    fin_slot       = '0;
    wr_entry.ip    = req_r.sender_ip;
    wr_entry.mac   = req_r.sender_mac;
    wr_entry.stamp = stamp_new;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_nxt        = in_data;
          ptr_nxt        = '0;
          issue_on_nxt   = 1'b1;
          found_nxt      = 1'b0;
          free_found_nxt = 1'b0;
          drop_nxt       = 1'b1;
          if (in_data.msg_len < ARP_MIN_LEN) begin
            drop_code_nxt = OUT_SHORT;
          end else if (in_data.hw_type != HTYPE_ETH) begin
            drop_code_nxt = OUT_BAD_HW;
          end else if (in_data.proto_type != PTYPE_IPV4) begin
            drop_code_nxt = OUT_BAD_PROTO;
          end else begin
            drop_nxt = 1'b0;
          end
          state_nxt = drop_nxt ? ST_FINISH : ST_SCAN;
        end
      end

      ST_SCAN: begin
        // Reads are issued one slot a cycle; the data of each comes back registered,
        // in the next cycle, and is folded into the running results.
        if (issue_on_r) begin
          ram_rd_en  = 1'b1;
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = ptr_r;
          if (ptr_r == LAST_IDX) begin
            issue_on_nxt = 1'b0;
          end else begin
            ptr_nxt = ptr_r + AW'(1);
          end
        end
        if (rd_vld_r) begin
          if (rd_slot_valid && (rd_entry.ip == req_r.sender_ip) && !found_r) begin
            found_nxt    = 1'b1;
            hit_slot_nxt = rd_idx_r;
          end
          if (!rd_slot_valid && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_slot_nxt  = rd_idx_r;
          end
          if ((rd_idx_r == '0) || (rd_stamp < min_stamp_r)) begin
            min_stamp_nxt = rd_stamp;
            min_slot_nxt  = rd_idx_r;
          end
          if (rd_idx_r == LAST_IDX) begin
            state_nxt = ST_FINISH;
          end
        end
      end

      ST_FINISH: begin
        res_valid = 1'b1;
        if (drop_r) begin
          res_data.outcome = drop_code_r;
        end else begin
          if (found_r) begin
            fin_slot         = hit_slot_r;
            res_data.outcome = OUT_UPDATED;
          end else if (for_us) begin
            fin_slot         = free_found_r ? free_slot_r : min_slot_r;
            res_data.outcome = OUT_INSERTED;
          end else begin
            res_data.outcome = OUT_IGNORED;
          end
          res_data.entry_slot = fin_slot_ext[4:0];
          if (for_us && (req_r.opcode == OP_REQUEST)) begin
            res_data.send_reply       = 1'b1;
            res_data.reply_sender_mac = cfg.own_mac;
            res_data.reply_sender_ip  = cfg.own_ip;
            res_data.reply_target_mac = req_r.sender_mac;
            res_data.reply_target_ip  = req_r.sender_ip;
          end
        end
        if (res_ready) begin
          state_nxt = ST_IDLE;
          if (!drop_r && (found_r || for_us)) begin
            ram_wr_en = 1'b1;
            set_valid = !found_r;
            wcnt_nxt  = stamp_new;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      issue_on_r <= 1'b0;
      rd_vld_r   <= 1'b0;
      wcnt_r     <= '0;
      valid_r    <= '0;
    end else begin
      state_r    <= state_nxt;
      issue_on_r <= issue_on_nxt;
      rd_vld_r   <= rd_vld_nxt;
      wcnt_r     <= wcnt_nxt;
      if (set_valid) begin
        valid_r[fin_slot] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    drop_r       <= drop_nxt;
    drop_code_r  <= drop_code_nxt;
    ptr_r        <= ptr_nxt;
    rd_idx_r     <= rd_idx_nxt;
    found_r      <= found_nxt;
    hit_slot_r   <= hit_slot_nxt;
    free_found_r <= free_found_nxt;
    free_slot_r  <= free_slot_nxt;
    min_stamp_r  <= min_stamp_nxt;
    min_slot_r   <= min_slot_nxt;
  end

endmodule

`default_nettype wire

>>> tb/sv/arp_receive_cache_checker.sv
// Checker for the ARP receive cache: watches the request, result and register
// channels, predicts each result from its own copy of the cache, and compares.
// Depends on arp_rc_pkg for the payload structs and the code constants.
`timescale 1ns / 1ps

module arp_receive_cache_checker
  import arp_rc_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_ready,
  input  wire arp_in_t              in_data,
  input  wire logic                 out_valid,
  input  wire logic                 out_ready,
  input  wire arp_out_t             out_data,
  input  wire logic                 cfg_valid,
  input  wire logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [47:0]          cfg_data,
  output int unsigned               mismatches,
  output int unsigned               pending
);

  logic [31:0] my_ip;
  logic [47:0] my_mac;
  logic        iface_on;

  logic        cache_valid [TABLE_ENTRIES];
  logic [31:0] cache_ip    [TABLE_ENTRIES];
  logic [47:0] cache_mac   [TABLE_ENTRIES];
  logic [31:0] cache_stamp [TABLE_ENTRIES];
  logic [31:0] write_count;

  arp_out_t expected_results[$];

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  // Works out the result of one request and applies its effect to the cache.
  function automatic arp_out_t apply_arp_message(input arp_in_t m);
    arp_out_t    r;
    int unsigned slot;
    logic        hit;
    logic        for_us;
    logic        found_free;
    r = '0;
    if (m.msg_len < ARP_MIN_LEN) begin
      r.outcome = OUT_SHORT;
      return r;
    end
    if (m.hw_type != HTYPE_ETH) begin
      r.outcome = OUT_BAD_HW;
      return r;
    end
    if (m.proto_type != PTYPE_IPV4) begin
      r.outcome = OUT_BAD_PROTO;
      return r;
    end
    hit = 1'b0;
    slot = 0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (!hit && cache_valid[i] && cache_ip[i] == m.sender_ip) begin
        hit = 1'b1;
        slot = i;
      end
    end
    for_us = iface_on && (m.target_ip == my_ip);
    if (!hit && for_us) begin
      // Lowest free slot first; otherwise the oldest stamp, lowest slot on a tie.
      found_free = 1'b0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (!found_free && !cache_valid[i]) begin
          found_free = 1'b1;
          slot = i;
        end
      end
      if (!found_free) begin
        for (int i = 1; i < TABLE_ENTRIES; i++) begin
          if (cache_stamp[i] < cache_stamp[slot]) slot = i;
        end
      end
      cache_valid[slot] = 1'b1;
      cache_ip[slot] = m.sender_ip;
    end
    if (hit || for_us) begin
      if (write_count != STAMP_MAX) write_count++;
      cache_mac[slot] = m.sender_mac;
      cache_stamp[slot] = write_count;
      r.outcome = hit ? OUT_UPDATED : OUT_INSERTED;
      r.entry_slot = 5'(slot);
    end else begin
      r.outcome = OUT_IGNORED;
    end
    if (for_us && m.opcode == OP_REQUEST) begin
      r.send_reply = 1'b1;
      r.reply_sender_mac = my_mac;
      r.reply_sender_ip = my_ip;
      r.reply_target_mac = m.sender_mac;
      r.reply_target_ip = m.sender_ip;
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    arp_out_t want;
    if (!rst_n) begin
      my_ip = '0;
      my_mac = '0;
      iface_on = 1'b0;
      write_count = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        cache_valid[i] = 1'b0;
        cache_ip[i] = '0;
        cache_mac[i] = '0;
        cache_stamp[i] = '0;
      end
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_OWN_IP:   my_ip = cfg_data[31:0];
          CFG_OWN_MAC:  my_mac = cfg_data;
          CFG_IFACE_EN: iface_on = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with none outstanding, outcome",
                          64'(out_data.outcome), 'x);
        end else begin
          want = expected_results.pop_front();
          if (out_data.outcome !== want.outcome)
            report_mismatch("outcome", 64'(out_data.outcome), 64'(want.outcome));
          if (out_data.entry_slot !== want.entry_slot)
            report_mismatch("entry_slot", 64'(out_data.entry_slot),
                            64'(want.entry_slot));
          if (out_data.send_reply !== want.send_reply)
            report_mismatch("send_reply", 64'(out_data.send_reply),
                            64'(want.send_reply));
          if (out_data.reply_sender_mac !== want.reply_sender_mac)
            report_mismatch("reply_sender_mac", 64'(out_data.reply_sender_mac),
                            64'(want.reply_sender_mac));
          if (out_data.reply_sender_ip !== want.reply_sender_ip)
            report_mismatch("reply_sender_ip", 64'(out_data.reply_sender_ip),
                            64'(want.reply_sender_ip));
          if (out_data.reply_target_mac !== want.reply_target_mac)
            report_mismatch("reply_target_mac", 64'(out_data.reply_target_mac),
                            64'(want.reply_target_mac));
          if (out_data.reply_target_ip !== want.reply_target_ip)
            report_mismatch("reply_target_ip", 64'(out_data.reply_target_ip),
                            64'(want.reply_target_ip));
        end
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(apply_arp_message(in_data));
      end
    end
    pending <= expected_results.size();
  end

endmodule

>>> tb/sv/tb_arp_receive_cache_core.sv
// Testbench top for arp_receive_cache_core: clock, reset, register writes,
// directed and random ARP requests, random back-pressure and the verdict.
// Depends on arp_rc_pkg, the design and arp_receive_cache_checker.
`timescale 1ns / 1ps

module tb_arp_receive_cache_core;
  import arp_rc_pkg::*;

  localparam int unsigned TABLE_ENTRIES = 32;
  localparam int unsigned RANDOM_MSGS   = 450;
  localparam int unsigned PHASES        = 5;
  localparam int unsigned POOL_SIZE     = 40;
  localparam logic [15:0] OP_REPLY      = 16'h0002;
  localparam logic [47:0] MAC_ONES      = 48'hFFFF_FFFF_FFFF;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  arp_in_t              in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  arp_out_t             out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_OWN_IP;
  logic [47:0]          cfg_data = '0;

  int unsigned mismatches;
  int unsigned pending;
  logic        steady = 1'b0;
  int unsigned ready_hold = 0;
  int unsigned ready_roll;
  logic [31:0] cur_ip = '0;
  logic [31:0] ip_pool [POOL_SIZE];

  always #5 clk = ~clk;

  arp_receive_cache_core #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  arp_receive_cache_checker #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) cache_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending)
  );

  // Result back-pressure: mostly short holds, now and then a long stall or a
  // long ready stretch; none at all while the steady phase runs.
  always @(posedge clk) begin
    if (steady) begin
      out_ready <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 55) begin
        out_ready <= 1'b1;
        ready_hold <= $urandom_range(0, 6);
      end else if (ready_roll < 65) begin
        out_ready <= 1'b1;
        ready_hold <= $urandom_range(30, 120);
      end else if (ready_roll < 95) begin
        out_ready <= 1'b0;
        ready_hold <= $urandom_range(0, 3);
      end else begin
        out_ready <= 1'b0;
        ready_hold <= $urandom_range(10, 60);
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned pick;
    if (steady) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 45) return 0;
    if (pick < 90) return $urandom_range(1, 4);
    return $urandom_range(15, 80);
  endfunction

  // Valid stays high from one request to the next when there is no gap.
  task automatic send_msg(input arp_in_t m);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= m;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Unused upper bits of the narrow registers carry random values.
  task automatic set_config(input logic [31:0] ip, input logic [47:0] mac, input logic en);
    write_reg(CFG_OWN_IP, {16'($urandom), ip});
    write_reg(CFG_OWN_MAC, mac);
    write_reg(CFG_IFACE_EN, {47'($urandom), en});
    cur_ip = ip;
  endtask

  // Holds off new requests until every outstanding result has been taken.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0 || out_valid);
    repeat (4) @(posedge clk);
  endtask

  function automatic arp_in_t make_msg(input logic [15:0] op, input logic [31:0] sip,
                                       input logic [31:0] tip);
    arp_in_t m;
    m.msg_len = 16'($urandom_range(ARP_MIN_LEN, 16'hFFFF));
    m.hw_type = HTYPE_ETH;
    m.proto_type = PTYPE_IPV4;
    m.opcode = op;
    m.sender_mac = {16'($urandom), $urandom};
    m.sender_ip = sip;
    m.target_ip = tip;
    return m;
  endfunction

  // Mostly well-formed messages from a pool a little larger than the table,
  // so that inserts soon start evicting; the rest are malformed or noise.
  function automatic arp_in_t random_msg();
    arp_in_t     m;
    int unsigned pick;
    logic [31:0] sip;
    logic [31:0] tip;
    logic [15:0] op;
    pick = $urandom_range(0, 99);
    if (pick < 80) sip = ip_pool[$urandom_range(0, POOL_SIZE - 1)];
    else sip = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 55) tip = cur_ip;
    else if (pick < 75) tip = ip_pool[$urandom_range(0, POOL_SIZE - 1)];
    else tip = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 45) op = OP_REQUEST;
    else if (pick < 85) op = OP_REPLY;
    else op = 16'($urandom);
    m = make_msg(op, sip, tip);
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      m.msg_len = 16'($urandom_range(0, ARP_MIN_LEN - 1));
    end else if (pick < 14) begin
      m.hw_type = 16'($urandom);
    end else if (pick < 20) begin
      m.proto_type = 16'($urandom);
    end else if (pick < 24) begin
      m.msg_len = 16'($urandom);
      m.hw_type = 16'($urandom);
      m.proto_type = 16'($urandom);
    end
    return m;
  endfunction

  initial begin
    #5_000_000;
    $display("arp_receive_cache_core verification failed");
    $finish;
  end

  initial begin
    arp_in_t m;
    for (int i = 0; i < POOL_SIZE; i++) ip_pool[i] = $urandom;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Drops of every kind, then a good request while the interface is off.
    m = make_msg(OP_REQUEST, ip_pool[0], '0);
    m.msg_len = '0;
    send_msg(m);
    m.msg_len = ARP_MIN_LEN - 16'd1;
    send_msg(m);
    m.msg_len = ARP_MIN_LEN;
    m.hw_type = '0;
    send_msg(m);
    m.msg_len = 16'hFFFF;
    m.hw_type = 16'hFFFF;
    send_msg(m);
    m.hw_type = HTYPE_ETH;
    m.proto_type = 16'h0806;
    send_msg(m);
    m.proto_type = 16'hFFFF;
    send_msg(m);
    m.proto_type = PTYPE_IPV4;
    send_msg(m);
    wait_idle();

    // Inserts with each kind of opcode, refreshes with and without a reply.
    set_config(32'hC0A8_0001, 48'h0200_0000_0001, 1'b1);
    m = make_msg(OP_REQUEST, ip_pool[0], cur_ip);
    m.msg_len = ARP_MIN_LEN;
    send_msg(m);
    send_msg(make_msg(OP_REPLY, ip_pool[1], cur_ip));
    send_msg(make_msg(16'hFFFF, ip_pool[2], cur_ip));
    send_msg(make_msg(16'h0000, ip_pool[3], cur_ip));
    send_msg(make_msg(OP_REPLY, ip_pool[0], ~cur_ip));
    send_msg(make_msg(OP_REQUEST, ip_pool[1], cur_ip));
    send_msg(make_msg(OP_REQUEST, ip_pool[4], ~cur_ip));
    m = make_msg(OP_REQUEST, 32'hFFFF_FFFF, cur_ip);
    m.sender_mac = MAC_ONES;
    send_msg(m);
    m = make_msg(OP_REQUEST, '0, cur_ip);
    m.sender_mac = '0;
    send_msg(m);
    wait_idle();

    set_config(32'hFFFF_FFFF, MAC_ONES, 1'b1);
    send_msg(make_msg(OP_REQUEST, '0, cur_ip));
    wait_idle();

    // With the interface off, known senders are still refreshed.
    set_config('0, '0, 1'b0);
    send_msg(make_msg(OP_REQUEST, ip_pool[0], cur_ip));
    send_msg(make_msg(OP_REQUEST, ip_pool[5], cur_ip));

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      steady <= (ph == 1);
      case (ph)
        0: set_config($urandom, {16'($urandom), $urandom}, 1'b1);
        1: set_config('0, '0, 1'b1);
        2: set_config($urandom, {16'($urandom), $urandom}, 1'b0);
        3: set_config(32'hFFFF_FFFF, MAC_ONES, 1'b1);
        default: set_config($urandom, {16'($urandom), $urandom}, 1'b1);
      endcase
      repeat (RANDOM_MSGS / PHASES) send_msg(random_msg());
    end
    steady <= 1'b0;
    wait_idle();
    repeat (TABLE_ENTRIES + 8) @(posedge clk);

    if (mismatches == 0) begin
      $display("arp_receive_cache_core verification clean");
    end else begin
      $display("arp_receive_cache_core verification failed");
    end
    $finish;
  end

endmodule
